// ===== design/assert_macros.svh =====
// Assertion macros shared by the integrator RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PKE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PKE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pke_pkg.sv =====
// Shared types, constants and saturating helpers of the Euler integrator.
// No dependencies.
package pke_pkg;
	localparam int Q_W         = 64;
	localparam int FRAC_BITS   = 32;
	localparam int SAVE_STRIDE = 10;
	localparam int CNT_W       = 7;
	localparam int MU_W        = 63;
	localparam int H_W         = 33;
	localparam int NSTEP_W     = 32;
	localparam int SAVE_W      = 4;

	localparam logic [1:0] REG_GRAVITY = 2'd0;
	localparam logic [1:0] REG_PERTURB = 2'd1;
	localparam logic [1:0] REG_STEP    = 2'd2;
	localparam logic [1:0] REG_COUNT   = 2'd3;

	localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	function automatic logic [Q_W-1:0] magn(input logic [Q_W-1:0] a);
		return a[Q_W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic [Q_W-1:0] from_mag(input logic neg, input logic [Q_W-1:0] m);
		if (neg)
			return (m >= Q_MIN) ? Q_MIN : (~m + 1'b1);
		return (m > Q_MAX) ? Q_MAX : m;
	endfunction

	function automatic logic [Q_W-1:0] sat_add(input logic [Q_W-1:0] a,
	                                            input logic [Q_W-1:0] b);
		logic [Q_W-1:0] s;
		s = a + b;
		if (a[Q_W-1] == b[Q_W-1] && s[Q_W-1] != a[Q_W-1])
			return a[Q_W-1] ? Q_MIN : Q_MAX;
		return s;
	endfunction

	function automatic logic [Q_W-1:0] sat_neg(input logic [Q_W-1:0] a);
		return (a == Q_MIN) ? Q_MAX : (~a + 1'b1);
	endfunction
endpackage

// ===== design/pke_alu.sv =====
// Bit-serial shared arithmetic unit: Q multiply, Q divide and integer square root.
// Depends on pke_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pke_alu (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pke_pkg::alu_req_t      req,
	input  logic [pke_pkg::Q_W-1:0]   opa,
	input  logic [pke_pkg::Q_W-1:0]   opb,
	input  logic [2*pke_pkg::Q_W-1:0] sq,
	output logic                   done,
	output logic [pke_pkg::Q_W-1:0]   res,
	output logic [2*pke_pkg::Q_W-1:0] prod
);
	import pke_pkg::*;

	localparam logic [CNT_W-1:0] MUL_CYC  = CNT_W'(Q_W);
	localparam logic [CNT_W-1:0] DIV_CYC  = CNT_W'(Q_W + FRAC_BITS);
	localparam logic [CNT_W-1:0] SQRT_CYC = CNT_W'(Q_W);

	logic                   busy_q, done_q, sign_q, zero_q, dz_q;
	alu_op_t                op_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [2*Q_W-1:0]       acc_q;
	logic [Q_W-1:0]         opd_q, root_q, res_q;
	logic [Q_W+1:0]         rem_q;

	logic [Q_W:0]           mul_sum;
	logic [Q_W:0]           div_trial;
	logic                   div_ge;
	logic [Q_W+2:0]         sq_rem, sq_trial;
	logic                   sq_ge;
	logic [Q_W-1:0]         fin_res;

	always_comb begin
		mul_sum   = {1'b0, acc_q[2*Q_W-1:Q_W]} + (acc_q[0] ? {1'b0, opd_q} : '0);
		div_trial = {rem_q[Q_W-1:0], acc_q[2*Q_W-1]};
		div_ge    = div_trial >= {1'b0, opd_q};
		sq_rem    = {rem_q[Q_W:0], acc_q[2*Q_W-1:2*Q_W-2]};
		sq_trial  = {1'b0, root_q, 2'b01};
		sq_ge     = sq_rem >= sq_trial;
	end

	always_comb begin
		unique case (op_q)
			OP_MUL: begin
				if (acc_q[2*Q_W-1:Q_W+FRAC_BITS] != '0)
					fin_res = from_mag(sign_q, '1);
				else
					fin_res = from_mag(sign_q, acc_q[Q_W+FRAC_BITS-1:FRAC_BITS]);
			end
			OP_DIV: begin
				if (zero_q)
					fin_res = '0;
				else if (dz_q || acc_q[Q_W+FRAC_BITS-1:Q_W] != '0)
					fin_res = from_mag(sign_q, '1);
				else
					fin_res = from_mag(sign_q, acc_q[Q_W-1:0]);
			end
			OP_SQRT: fin_res = root_q;
			default: fin_res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				rem_q  <= '0;
				root_q <= '0;
				unique case (req.op)
					OP_MUL: begin
						opd_q  <= magn(opa);
						acc_q  <= {{Q_W{1'b0}}, magn(opb)};
						sign_q <= opa[Q_W-1] ^ opb[Q_W-1];
						cnt_q  <= MUL_CYC;
					end
					OP_DIV: begin
						opd_q  <= opb;
						acc_q  <= {magn(opa), {Q_W{1'b0}}};
						sign_q <= opa[Q_W-1];
						zero_q <= (opa == '0);
						dz_q   <= (opb == '0);
						// Degenerate cases finish without iterating.
						cnt_q  <= (opa == '0 || opb == '0) ? '0 : DIV_CYC;
					end
					OP_SQRT: begin
						acc_q <= sq;
						cnt_q <= SQRT_CYC;
					end
					default: cnt_q <= '0;
				endcase
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q  <= fin_res;
				end else begin
					cnt_q <= cnt_q - 1'b1;
					unique case (op_q)
						OP_MUL: acc_q <= {mul_sum, acc_q[Q_W-1:1]};
						OP_DIV: begin
							acc_q <= {acc_q[2*Q_W-2:0], div_ge};
							if (div_ge)
								rem_q <= {1'b0, (div_trial - {1'b0, opd_q})};
							else
								rem_q <= {1'b0, div_trial};
						end
						OP_SQRT: begin
							acc_q  <= {acc_q[2*Q_W-3:0], 2'b00};
							root_q <= {root_q[Q_W-2:0], sq_ge};
							if (sq_ge)
								rem_q <= Q_W'(0) + (Q_W+2)'(sq_rem - sq_trial);
							else
								rem_q <= (Q_W+2)'(sq_rem);
						end
						default: acc_q <= acc_q;
					endcase
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign prod = acc_q;

	`PKE_ASSERT(a_cnt_range, busy_q |-> (cnt_q <= DIV_CYC), "alu counter out of range")
	`PKE_ASSERT(a_done_pulse, done_q |-> !busy_q, "alu done while still busy")
	`PKE_ASSERT(a_done_from_busy, done_q |-> $past(busy_q), "alu done without a running op")
endmodule

// ===== design/perturbed_kepler_euler_step.sv =====
// Perturbed Kepler orbit integrator, one explicit Euler step per tick request.
// A start request loads the state and goes straight to the output state, which loads the output
// register once it is free. A tick runs three squares, a square root, eight divisions and nine
// products in the shared bit-serial unit, then forms the coefficient and closes the step; it gives
// a sample only every tenth step or on the last. A division with a zero operand finishes without
// iterating, and a stalled output holds the sequencer. Async active-low reset.
`include "assert_macros.svh"
module perturbed_kepler_euler_step (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// init_pos_x, init_pos_y, init_pos_z, init_vel_x, init_vel_y, init_vel_z
	input  logic [383:0] s_tdata,
	// start_req
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, sim_time, one zero pad bit
	output logic [447:0] m_tdata,
	// final_sample
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import pke_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_DIVA, ST_DIVB, ST_COEF,
		ST_ACC, ST_POS, ST_VEL, ST_FIN, ST_OUT
	} state_t;

	// Configuration registers.
	logic [MU_W-1:0]    mu_q;
	logic [Q_W-1:0]     delta_q;
	logic [H_W-1:0]     h_q;
	logic [NSTEP_W-1:0] nstep_q;

	// Orbit state: position and velocity components.
	logic [Q_W-1:0]     pos_q [3];
	logic [Q_W-1:0]     vel_q [3];
	logic [Q_W-2:0]     time_q;
	logic [NSTEP_W-1:0] step_q;
	logic [SAVE_W-1:0]  save_q;
	logic               running_q;

	// Sequencer and scratch registers.
	state_t             state_q;
	logic [2:0]         idx_q;
	logic               wait_q;
	logic               final_q;
	logic [2*Q_W-1:0]   sum_q;
	logic [Q_W-1:0]     r_q, qa_q, qb_q, c_q, tmp_q;

	// Output register.
	logic               ovalid_q, olast_q;
	logic [Q_W-1:0]     opos_q [3];
	logic [Q_W-1:0]     ovel_q [3];
	logic [Q_W-2:0]     otime_q;

	alu_req_t           alu_req;
	logic [Q_W-1:0]     alu_a, alu_b, alu_res;
	logic [2*Q_W-1:0]   alu_prod;
	logic               alu_done;
	logic [1:0]         cidx;
	logic [Q_W-1:0]     h_ext, mu_ext;
	logic [Q_W-1:0]     time_sum;
	logic [NSTEP_W-1:0] step_nxt;
	logic [SAVE_W-1:0]  save_nxt;
	logic               periodic, last;
	logic               in_acc, out_free;

	assign cidx     = idx_q[1:0];
	assign h_ext    = {{(Q_W-H_W){1'b0}}, h_q};
	assign mu_ext   = {1'b0, mu_q};
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !ovalid_q || m_tready;

	assign time_sum = {1'b0, time_q} + h_ext;
	assign step_nxt = step_q + 1'b1;
	assign save_nxt = save_q + 1'b1;
	assign periodic = save_nxt >= SAVE_W'(SAVE_STRIDE);
	assign last     = step_nxt >= nstep_q;

	// The arithmetic unit is started once for each operation of a working state and
	// the sequencer holds until its done pulse.
	always_comb begin
		alu_req.start = !wait_q;
		alu_req.op    = OP_MUL;
		alu_a         = '0;
		alu_b         = '0;
		unique case (state_q)
			ST_SQ: begin
				alu_a = pos_q[cidx];
				alu_b = pos_q[cidx];
			end
			ST_SQRT: alu_req.op = OP_SQRT;
			ST_DIVA: begin
				alu_req.op = OP_DIV;
				alu_a      = qa_q;
				alu_b      = r_q;
			end
			ST_DIVB: begin
				alu_req.op = OP_DIV;
				alu_a      = qb_q;
				alu_b      = r_q;
			end
			ST_ACC: begin
				alu_a = c_q;
				alu_b = pos_q[cidx];
			end
			ST_POS: begin
				alu_a = h_ext;
				alu_b = vel_q[cidx];
			end
			ST_VEL: begin
				alu_a = h_ext;
				alu_b = tmp_q;
			end
			default: alu_req.start = 1'b0;
		endcase
	end

	pke_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (alu_a),
		.opb    (alu_b),
		.sq     (sum_q),
		.done   (alu_done),
		.res    (alu_res),
		.prod   (alu_prod)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q    <= MU_W'(64'd4294967296);
			delta_q <= '0;
			h_q     <= H_W'(64'd4294967);
			nstep_q <= NSTEP_W'(1000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAVITY: mu_q    <= cfg_data[MU_W-1:0];
				REG_PERTURB: delta_q <= cfg_data;
				REG_STEP:    h_q     <= cfg_data[H_W-1:0];
				REG_COUNT:   nstep_q <= cfg_data[NSTEP_W-1:0];
				default:     mu_q    <= mu_q;
			endcase
		end
	end

	// Sequencer, orbit state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			wait_q    <= 1'b0;
			running_q <= 1'b0;
			ovalid_q  <= 1'b0;
			time_q    <= '0;
			step_q    <= '0;
			save_q    <= '0;
			final_q   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			if (alu_done)
				wait_q <= 1'b0;
			else if (alu_req.start)
				wait_q <= 1'b1;
			// The output register is loaded from the sample state and emptied
			// when the receiver takes it.
			if (state_q == ST_OUT && out_free)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser) begin
							for (int i = 0; i < 3; i++) begin
								pos_q[i] <= s_tdata[64*i +: 64];
								vel_q[i] <= s_tdata[64*(i+3) +: 64];
							end
							time_q    <= '0;
							step_q    <= '0;
							save_q    <= '0;
							running_q <= (nstep_q != '0);
							final_q   <= (nstep_q == '0);
							state_q   <= ST_OUT;
						end else if (running_q) begin
							idx_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					if (alu_done) begin
						sum_q <= sum_q + alu_prod;
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd2)
							state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (alu_done) begin
						r_q     <= alu_res;
						qa_q    <= mu_ext;
						qb_q    <= delta_q;
						idx_q   <= '0;
						state_q <= ST_DIVA;
					end
				end
				ST_DIVA: begin
					// mu / r^3 as three successive quotients.
					if (alu_done) begin
						qa_q <= alu_res;
						if (idx_q == 3'd2) begin
							idx_q   <= '0;
							state_q <= ST_DIVB;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DIVB: begin
					// delta / r^5 as five successive quotients.
					if (alu_done) begin
						qb_q  <= alu_res;
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd4)
							state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					c_q     <= sat_neg(sat_add(qa_q, sat_add(qb_q, sat_add(qb_q, qb_q))));
					idx_q   <= '0;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// Acceleration uses the position before this component moves.
					if (alu_done) begin
						tmp_q   <= alu_res;
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					if (alu_done) begin
						pos_q[cidx] <= sat_add(pos_q[cidx], alu_res);
						state_q     <= ST_VEL;
					end
				end
				ST_VEL: begin
					if (alu_done) begin
						vel_q[cidx] <= sat_add(vel_q[cidx], alu_res);
						idx_q       <= idx_q + 1'b1;
						state_q     <= (idx_q == 3'd2) ? ST_FIN : ST_ACC;
					end
				end
				ST_FIN: begin
					time_q  <= time_sum[Q_W-1] ? {(Q_W-1){1'b1}} : time_sum[Q_W-2:0];
					step_q  <= step_nxt;
					save_q  <= periodic ? '0 : save_nxt;
					final_q <= last;
					if (last)
						running_q <= 1'b0;
					state_q <= (periodic || last) ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (out_free) begin
						olast_q  <= final_q;
						otime_q  <= time_q;
						for (int i = 0; i < 3; i++) begin
							opos_q[i] <= pos_q[i];
							ovel_q[i] <= vel_q[i];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {1'b0, otime_q, ovel_q[2], ovel_q[1], ovel_q[0],
	                   opos_q[2], opos_q[1], opos_q[0]};

	`PKE_ASSERT(a_step_needs_run, (state_q == ST_SQ) |-> running_q, "step without a run")
	`PKE_ASSERT(a_done_when_waiting, alu_done |-> wait_q, "unexpected alu completion")
	`PKE_ASSERT(a_idx_range, (state_q == ST_ACC || state_q == ST_POS) |-> (idx_q <= 3'd2),
		"component index out of range")
	`PKE_ASSERT(a_out_hold, (state_q == ST_OUT && !out_free) |=> (state_q == ST_OUT),
		"sample dropped while output busy")
endmodule
